/* rtl/core/bart_pkg.sv */
// shared types and constants of the block average reference tracker
`timescale 1ns / 1ps

package bart_pkg;

  // samples per averaging block, range 2 to 128
  localparam int unsigned BLOCK_LEN = 100;
  localparam logic [7:0] BlockLenW = 8'(BLOCK_LEN);

  // block mean as a reciprocal multiply, exact for every 16-bit block sum
  localparam int unsigned MeanShift = 16 + $clog2(BLOCK_LEN);
  localparam logic [17:0] MeanRecip = 18'((1 << MeanShift) / BLOCK_LEN + 1);

  localparam logic [7:0] RefOffset  = 8'd180;
  localparam logic [7:0] LevelReset = 8'd127;

  // queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  // requests the block can hold at once: front stage, queue, back, result register
  localparam int unsigned ItemCap = QDepth + 3;

  typedef enum logic [1:0] {
    REG_GAIN    = 2'd0,
    REG_RED_THR = 2'd1,
    REG_IR_THR  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MEAN,
    BK_LVL,
    BK_NUM,
    BK_REF,
    BK_OUT
  } back_state_e;

  typedef struct packed {
    logic [5:0] gain;
    logic [7:0] red_thr;
    logic [7:0] ir_thr;
  } cfg_t;

  typedef struct packed {
    logic        ch;
    logic [13:0] dc;
    logic [7:0]  sbyte;
  } item_t;

  typedef struct packed {
    logic        ch;
    logic [13:0] dc;
    logic        done;
    logic [7:0]  lvl;
    logic [7:0]  refv;
  } result_t;

endpackage

/* rtl/core/bart_front.sv */
// front stage: takes requests and splits the raw word into dc level and sample byte
`timescale 1ns / 1ps

module bart_front import bart_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic        channel_i,
  input  logic [15:0] raw_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output item_t       item_o
);

  logic  vld_q, vld_d;
  item_t item_q;
  logic  take;

  assign q_push_o = vld_q && !q_full_i;
  assign full_o   = vld_q && q_full_i;
  assign take     = push_i && !full_o;
  assign item_o   = item_q;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (q_push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.ch    <= channel_i;
      item_q.dc    <= raw_i[15:2];
      item_q.sbyte <= raw_i[14:7];
    end
  end

endmodule

/* rtl/core/bart_fifo.sv */
// short request queue between front and back
`timescale 1ns / 1ps

module bart_fifo import bart_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t data_o
);

  item_t            mem_q [QDepth];
  logic [QAw-1:0]   wptr_q, rptr_q;
  logic [QCw-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCw'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCw'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCw'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= QAw'(wptr_q + QAw'(1));
      end
      if (pop_i) begin
        rptr_q <= QAw'(rptr_q + QAw'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

/* rtl/core/bart_div.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module bart_div import bart_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [7:0]  divisor_i,
  output logic        done_o,
  output logic [15:0] quot_o
);

  logic        busy_q, done_q;
  logic [3:0]  cnt_q;
  logic [15:0] dvd_q;
  logic [7:0]  rem_q, dsr_q;
  logic [8:0]  trial;
  logic        ge;

  assign trial  = {rem_q, dvd_q[15]};
  assign ge     = trial >= {1'b0, dsr_q};
  assign done_o = done_q;
  assign quot_o = dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd15;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 4'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[14:0], ge};
      rem_q <= ge ? 8'(trial - {1'b0, dsr_q}) : trial[7:0];
    end
  end

endmodule

/* rtl/core/bart_back.sv */
// back end: per channel accumulation, block mean, hysteresis and reference
`timescale 1ns / 1ps

module bart_back import bart_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    q_empty_i,
  input  item_t   q_item_i,
  output logic    q_pop_o,
  input  logic    res_take_i,
  output logic    res_valid_o,
  output result_t res_o
);

  back_state_e state_q, state_d;

  logic [6:0]  cnt_q [2];
  logic [15:0] sum_q [2];
  logic [7:0]  lvl_q [2];
  logic [7:0]  ref_q [2];

  logic        cur_ch_q;
  logic [13:0] cur_dc_q;
  logic [15:0] cur_sum_q;
  logic [7:0]  mean_q;
  logic        res_valid_q;
  result_t     res_q, res_d;

  logic        ch;
  logic [6:0]  cnt_inc;
  logic [15:0] sum_add;
  logic        blk_end;
  logic        out_free;
  logic [7:0]  lvl_cur, diff, thr;
  logic [13:0] prod;
  logic [15:0] numer;
  logic [33:0] mean_prod;
  logic [7:0]  mean_d;

  logic        acc_we, cur_load, mean_load, lvl_we, ref_we, res_load;
  logic        div_start, div_done;
  logic [15:0] div_dvd, div_quot;
  logic [7:0]  div_dsr;

  bart_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign ch       = q_item_i.ch;
  assign cnt_inc  = cnt_q[ch] + 7'd1;
  assign sum_add  = sum_q[ch] + {8'd0, q_item_i.sbyte};
  assign blk_end  = ({1'b0, cnt_inc} >= BlockLenW) || (cnt_inc == '0);
  assign out_free = !res_valid_q || res_take_i;

  // block mean: sum times reciprocal, keep the low byte of the quotient
  assign mean_prod = 34'(cur_sum_q) * 34'(MeanRecip);
  assign mean_d    = mean_prod[MeanShift +: 8];

  assign lvl_cur = lvl_q[cur_ch_q];
  assign diff    = (mean_q >= lvl_cur) ? (mean_q - lvl_cur) : (lvl_cur - mean_q);
  assign thr     = cur_ch_q ? cfg_i.ir_thr : cfg_i.red_thr;
  assign prod    = 14'(cfg_i.gain) * 14'(lvl_cur);
  assign numer   = 16'(prod) + 16'(RefOffset);

  assign div_dvd = numer;
  assign div_dsr = 8'(cfg_i.gain) + 8'd1;

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    acc_we    = 1'b0;
    cur_load  = 1'b0;
    mean_load = 1'b0;
    lvl_we    = 1'b0;
    ref_we    = 1'b0;
    res_load  = 1'b0;
    div_start = 1'b0;
    res_d     = res_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i && out_free) begin
          q_pop_o = 1'b1;
          acc_we  = 1'b1;
          if (blk_end) begin
            cur_load = 1'b1;
            state_d  = BK_MEAN;
          end else begin
            res_load   = 1'b1;
            res_d.ch   = ch;
            res_d.dc   = q_item_i.dc;
            res_d.done = 1'b0;
            res_d.lvl  = lvl_q[ch];
            res_d.refv = ref_q[ch];
          end
        end
      end
      BK_MEAN: begin
        mean_load = 1'b1;
        state_d   = BK_LVL;
      end
      BK_LVL: begin
        lvl_we  = diff > thr;
        state_d = BK_NUM;
      end
      BK_NUM: begin
        div_start = 1'b1;
        state_d   = BK_REF;
      end
      BK_REF: begin
        if (div_done) begin
          ref_we  = 1'b1;
          state_d = BK_OUT;
        end
      end
      BK_OUT: begin
        if (out_free) begin
          res_load   = 1'b1;
          res_d.ch   = cur_ch_q;
          res_d.dc   = cur_dc_q;
          res_d.done = 1'b1;
          res_d.lvl  = lvl_cur;
          res_d.refv = ref_q[cur_ch_q];
          state_d    = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      res_valid_q <= 1'b0;
      cnt_q[0]    <= '0;
      cnt_q[1]    <= '0;
      sum_q[0]    <= '0;
      sum_q[1]    <= '0;
      lvl_q[0]    <= LevelReset;
      lvl_q[1]    <= LevelReset;
      ref_q[0]    <= '0;
      ref_q[1]    <= '0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_take_i) begin
        res_valid_q <= 1'b0;
      end
      if (acc_we) begin
        cnt_q[ch] <= blk_end ? '0 : cnt_inc;
        sum_q[ch] <= blk_end ? '0 : sum_add;
      end
      if (lvl_we) begin
        lvl_q[cur_ch_q] <= mean_q;
      end
      if (ref_we) begin
        ref_q[cur_ch_q] <= div_quot[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_load) begin
      cur_ch_q  <= ch;
      cur_dc_q  <= q_item_i.dc;
      cur_sum_q <= sum_add;
    end
    if (mean_load) begin
      mean_q <= mean_d;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

endmodule

/* rtl/core/block_average_reference_tracker_core.sv */
// top level of the block average reference tracker
`timescale 1ns / 1ps

// two channel block average reference tracker. each request carries one raw
// 16-bit converter word and its channel (0 red, 1 infrared) and gives exactly
// one result: the dc level (word >> 2), a block done flag and the channel's
// tracked level and reference after this sample. bits 14:7 of the word are
// summed per channel; every BLOCK_LEN samples the block mean replaces the
// tracked level when it moved by more than that channel's threshold, and the
// reference becomes (180 + gain*level) / (1 + gain). a sample that does not
// end a block passes the back end directly into the result register, so such
// requests flow at one per cycle while the result register is free or being
// popped. a sample that ends a block holds the back end while it steps
// through: accumulate, block mean by reciprocal multiply, hysteresis compare,
// divider start, the divider making one quotient bit per cycle for the
// reference, and loading the result once the result register is free.
// meanwhile the front register and a two entry queue keep taking requests until they fill. configuration
// writes are always ready and should only be issued while the block is idle.
module block_average_reference_tracker_core import bart_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        push,
  output logic        full,
  input  logic        channel_i,
  input  logic [15:0] raw_sample_i,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic        out_channel_o,
  output logic [13:0] dc_level_o,
  output logic        block_done_o,
  output logic [7:0]  tracked_level_o,
  output logic [7:0]  reference_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  cfg_t    cfg_q;
  logic    q_push, q_full, q_pop, q_empty;
  item_t   fr_item, q_item;
  logic    res_valid;
  result_t res;

  // register file, unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain    <= 6'd1;
      cfg_q.red_thr <= 8'd2;
      cfg_q.ir_thr  <= 8'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_GAIN:    cfg_q.gain    <= cfg_data_i[5:0];
        REG_RED_THR: cfg_q.red_thr <= cfg_data_i;
        REG_IR_THR:  cfg_q.ir_thr  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // front: input register and field split
  bart_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .channel_i (channel_i),
    .raw_i     (raw_sample_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .item_o    (fr_item)
  );

  // decoupling queue
  bart_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (fr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_item)
  );

  // back: accumulation, divider, result register
  bart_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .res_take_i  (pop && res_valid),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign empty           = !res_valid;
  assign out_channel_o   = res.ch;
  assign dc_level_o      = res.dc;
  assign block_done_o    = res.done;
  assign tracked_level_o = res.lvl;
  assign reference_o     = res.refv;

endmodule

/* rtl/core/bart_checker.sv */
// port level checker for the tracker core and its bind
`timescale 1ns / 1ps

module bart_checker import bart_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        out_channel_o,
  input logic [13:0] dc_level_o,
  input logic        block_done_o,
  input logic [7:0]  tracked_level_o,
  input logic [7:0]  reference_o,
  input logic        cfg_ready_o
);

  localparam int unsigned OcW = $clog2(ItemCap + 1);

  logic [OcW-1:0] outst_q;
  logic           in_acc, out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else if (in_acc && !out_acc) begin
      outst_q <= outst_q + OcW'(1);
    end else if (out_acc && !in_acc) begin
      outst_q <= outst_q - OcW'(1);
    end
  end

  // no result without a request in flight
  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> outst_q != '0)
    else $error("result delivered with no request outstanding");

  // full must rise before the internal storage overflows
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> outst_q < OcW'(ItemCap))
    else $error("request taken beyond block capacity");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_channel_o) && $stable(dc_level_o)
      && $stable(block_done_o) && $stable(tracked_level_o) && $stable(reference_o)))
    else $error("waiting result changed or vanished");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind block_average_reference_tracker_core bart_checker u_bart_checker (.*);
